FILE: hw/rtl/cpbf_pkg.sv
// Shared constants and controller/datapath interface types for the peak bandwidth finder.
package cpbf_pkg;

    // Spectrum length. It must be a power of two: the bin-to-hertz scaling is a shift.
    localparam int BINS      = 1024;
    localparam int MAX_PEAKS = 32;

    localparam int IDX_W     = $clog2(BINS);
    localparam int POWER_W   = 16;
    localparam int RATE_W    = 30;
    localparam int FREQ_W    = 30;
    localparam int PROD_W    = IDX_W + RATE_W;
    localparam int NUM_W     = 5;
    localparam int CNT_OUT_W = 9;
    localparam int CNT_MAX   = 511;
    localparam int SAT_W     = (IDX_W > CNT_OUT_W) ? IDX_W : CNT_OUT_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

    // One bit per datapath action; the controller raises at most a few at once.
    typedef struct packed {
        logic load_wr;
        logic prime0;
        logic prime1;
        logic cap_mid;
        logic adv_test;
        logic peak_start;
        logic walk_l_step;
        logic walk_l_done;
        logic walk_r_step;
        logic walk_r_done;
        logic mul_w;
        logic emit_peak;
        logic peak_adv;
        logic emit_sum;
    } t_cmd;

    typedef struct packed {
        logic last_bin;
        logic is_peak;
        logic walk_l_cont;
        logic walk_r_cont;
        logic scan_end;
        logic under_max;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/cpbf_ctrl.sv
// Sequencing state machine for loading, peak scan, width walks and result output.
module cpbf_ctrl
    import cpbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_PRIME0 = 4'd1;
    localparam logic [3:0] S_PRIME1 = 4'd2;
    localparam logic [3:0] S_MID    = 4'd3;
    localparam logic [3:0] S_TEST   = 4'd4;
    localparam logic [3:0] S_WALKL  = 4'd5;
    localparam logic [3:0] S_WALKR  = 4'd6;
    localparam logic [3:0] S_MULW   = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_status.last_bin) begin
                        n_state = S_PRIME0;
                    end
                end
            end
            S_PRIME0: begin
                o_cmd.prime0 = 1'b1;
                n_state      = S_PRIME1;
            end
            S_PRIME1: begin
                o_cmd.prime1 = 1'b1;
                n_state      = S_MID;
            end
            S_MID: begin
                o_cmd.cap_mid = 1'b1;
                n_state       = S_TEST;
            end
            S_TEST: begin
                priority if (i_status.is_peak) begin
                    o_cmd.peak_start = 1'b1;
                    n_state          = S_WALKL;
                end else if (i_status.scan_end) begin
                    n_state = S_SUM;
                end else begin
                    o_cmd.adv_test = 1'b1;
                end
            end
            S_WALKL: begin
                if (i_status.walk_l_cont) begin
                    o_cmd.walk_l_step = 1'b1;
                end else begin
                    o_cmd.walk_l_done = 1'b1;
                    n_state           = S_WALKR;
                end
            end
            S_WALKR: begin
                if (i_status.walk_r_cont) begin
                    o_cmd.walk_r_step = 1'b1;
                end else begin
                    o_cmd.walk_r_done = 1'b1;
                    n_state           = S_MULW;
                end
            end
            S_MULW: begin
                o_cmd.mul_w = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.under_max || i_status.out_free) begin
                    o_cmd.emit_peak = i_status.under_max;
                    o_cmd.peak_adv  = 1'b1;
                    n_state         = i_status.scan_end ? S_SUM : S_TEST;
                end
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall = (r_state != S_LOAD);

endmodule

FILE: hw/rtl/cpbf_datapath.sv
// Spectrum memory, scan window, walk pointers, shared multiplier and output register.
module cpbf_datapath
    import cpbf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [POWER_W-1:0]   i_power,
    input  logic                 i_cfg_wr_en,
    input  logic [RATE_W-1:0]    i_cfg_wr_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic                 o_is_summary,
    output logic [NUM_W-1:0]     o_peak_number,
    output logic [FREQ_W-1:0]    o_center_freq_hz,
    output logic [FREQ_W-1:0]    o_bandwidth_hz,
    output logic [CNT_OUT_W-1:0] o_peak_count,
    output logic                 o_last
);

    logic [POWER_W-1:0] mem [BINS];
    logic [POWER_W-1:0] r_rd_data;
    logic [IDX_W-1:0]   rd_addr;

    logic [IDX_W-1:0]   r_load_idx;
    logic [RATE_W-1:0]  r_rate;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   r_lo;
    logic [IDX_W-1:0]   r_width;
    logic [IDX_W-1:0]   r_count;
    logic [POWER_W-1:0] r_left;
    logic [POWER_W-1:0] r_mid;
    logic [POWER_W-1:0] r_right;
    logic [PROD_W-1:0]  r_prod;
    logic [FREQ_W-1:0]  r_center;
    logic [IDX_W-1:0]   mul_a;
    logic [SAT_W-1:0]   cnt_ext;
    logic [CNT_OUT_W-1:0] cnt_sat;
    logic               twice_gt;

    logic                 r_out_valid;
    logic                 r_is_summary;
    logic [NUM_W-1:0]     r_peak_number;
    logic [FREQ_W-1:0]    r_center_freq;
    logic [FREQ_W-1:0]    r_bandwidth;
    logic [CNT_OUT_W-1:0] r_peak_count;
    logic                 r_last;

    // Read address for the next cycle's registered memory data.
    always_comb begin
        priority if (i_cmd.prime0) begin
            rd_addr = '0;
        end else if (i_cmd.prime1) begin
            rd_addr = IDX_W'(1);
        end else if (i_cmd.cap_mid) begin
            rd_addr = r_idx + IDX_W'(1);
        end else if (i_cmd.adv_test || i_cmd.peak_adv) begin
            rd_addr = r_idx + IDX_W'(2);
        end else if (i_cmd.walk_l_step) begin
            rd_addr = r_ptr - IDX_W'(1);
        end else if (i_cmd.walk_r_step) begin
            rd_addr = r_ptr + IDX_W'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mem[r_load_idx] <= i_power;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign twice_gt = {r_rd_data, 1'b0} > {1'b0, r_mid};
    assign cnt_ext  = SAT_W'(r_count);
    assign cnt_sat  = (cnt_ext > SAT_W'(CNT_MAX)) ? CNT_OUT_W'(CNT_MAX) : cnt_ext[CNT_OUT_W-1:0];
    assign mul_a    = i_cmd.walk_r_done ? r_idx : r_width;

    always_comb begin
        o_status.last_bin    = (r_load_idx == IDX_W'(BINS - 1));
        o_status.is_peak     = (r_mid > r_left) && (r_mid > r_rd_data);
        o_status.walk_l_cont = twice_gt && (r_ptr != '0);
        o_status.walk_r_cont = twice_gt && (r_ptr < IDX_W'(BINS / 2));
        o_status.scan_end    = (r_idx == IDX_W'(BINS - 2));
        o_status.under_max   = (cnt_ext < SAT_W'(MAX_PEAKS));
        o_status.out_free    = !r_out_valid || !i_stall;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx  <= '0;
            r_rate      <= RATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            if (i_cmd.load_wr) begin
                r_load_idx <= r_load_idx + IDX_W'(1);
            end
            if (i_cmd.emit_peak || i_cmd.emit_sum) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan window, walk pointers and products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prime0) begin
            r_count <= '0;
        end
        if (i_cmd.prime1) begin
            r_left <= r_rd_data;
            r_idx  <= IDX_W'(1);
        end
        if (i_cmd.cap_mid) begin
            r_mid <= r_rd_data;
        end
        if (i_cmd.adv_test) begin
            r_left <= r_mid;
            r_mid  <= r_rd_data;
            r_idx  <= r_idx + IDX_W'(1);
        end
        if (i_cmd.peak_start) begin
            r_right <= r_rd_data;
            r_ptr   <= r_idx;
        end
        if (i_cmd.walk_l_step) begin
            r_ptr <= r_ptr - IDX_W'(1);
        end
        if (i_cmd.walk_l_done) begin
            r_lo  <= r_ptr;
            r_ptr <= r_idx;
        end
        if (i_cmd.walk_r_step) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (i_cmd.walk_r_done) begin
            r_width <= r_ptr - r_lo;
        end
        if (i_cmd.walk_r_done || i_cmd.mul_w) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(r_rate);
        end
        if (i_cmd.mul_w) begin
            r_center <= r_prod[IDX_W +: FREQ_W];
        end
        if (i_cmd.peak_adv) begin
            r_count <= r_count + IDX_W'(1);
            r_left  <= r_mid;
            r_mid   <= r_right;
            r_idx   <= r_idx + IDX_W'(1);
        end
        if (i_cmd.emit_peak) begin
            r_is_summary  <= 1'b0;
            r_peak_number <= cnt_ext[NUM_W-1:0];
            r_center_freq <= r_center;
            r_bandwidth   <= r_prod[IDX_W +: FREQ_W];
            r_peak_count  <= '0;
            r_last        <= 1'b0;
        end
        if (i_cmd.emit_sum) begin
            r_is_summary  <= 1'b1;
            r_peak_number <= '0;
            r_center_freq <= '0;
            r_bandwidth   <= '0;
            r_peak_count  <= cnt_sat;
            r_last        <= 1'b1;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_is_summary     = r_is_summary;
    assign o_peak_number    = r_peak_number;
    assign o_center_freq_hz = r_center_freq;
    assign o_bandwidth_hz   = r_bandwidth;
    assign o_peak_count     = r_peak_count;
    assign o_last           = r_last;

endmodule

FILE: hw/rtl/comb_peak_bandwidth_finder.sv
// Top level of the spectral peak finder with half-power bandwidth measurement.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_power
//   output   out        o_valid / i_stall    o_is_summary, o_peak_number, o_center_freq_hz,
//                                            o_bandwidth_hz, o_peak_count, o_last
//   config   in         i_cfg_wr_en          i_cfg_wr_data (sample rate in hertz)
//
// Bins are taken one item per cycle into a dual-port spectrum memory until BINS are in.
// The last bin starts a scan, and o_stall stays high until the summary item is loaded
// into the output register. The scan primes the window in S_PRIME0, S_PRIME1 and S_MID,
// tests each bin in S_TEST and, for each peak, walks left and right with one memory read per
// step before S_MULW and S_EMIT; a stalled output register adds its wait. The memory contents
// are not reset. Reset is synchronous and active low and clears the state machine, the load
// counter, the output valid flag and the sample rate (back to one megahertz).
module comb_peak_bandwidth_finder
    import cpbf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [POWER_W-1:0]   i_power,
    input  logic                 i_cfg_wr_en,
    input  logic [RATE_W-1:0]    i_cfg_wr_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_is_summary,
    output logic [NUM_W-1:0]     o_peak_number,
    output logic [FREQ_W-1:0]    o_center_freq_hz,
    output logic [FREQ_W-1:0]    o_bandwidth_hz,
    output logic [CNT_OUT_W-1:0] o_peak_count,
    output logic                 o_last
);

    // The controller decides what happens each cycle; the datapath holds all the data.
    t_cmd    cmd;
    t_status status;

    cpbf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    // The output register decouples the scan from the downstream stall: a report waits
    // there while the walks for the next peak are already running.
    cpbf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_power          (i_power),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_is_summary     (o_is_summary),
        .o_peak_number    (o_peak_number),
        .o_center_freq_hz (o_center_freq_hz),
        .o_bandwidth_hz   (o_bandwidth_hz),
        .o_peak_count     (o_peak_count),
        .o_last           (o_last)
    );

endmodule
